/* rtl/esdpe_pkg.sv */
// ----------------------------------------------------------------------------
// esdpe_pkg
// Shared types and constants for the ES descriptor payload extractor.
// ----------------------------------------------------------------------------
package esdpe_pkg;

  // Parser phases, one per field of the descriptor.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LEN,
    PH_ESID,
    PH_FLAGS,
    PH_DEP,
    PH_URLLEN,
    PH_URL,
    PH_OCR,
    PH_DCTAG,
    PH_DCLEN,
    PH_DCFIX,
    PH_INTAG,
    PH_INLEN,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  // Stages of the optional field chain.
  typedef enum logic [1:0] {
    OPT_DEP,
    OPT_URL,
    OPT_OCR,
    OPT_NONE
  } opt_stage_t;

  // One payload word as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_word_t;

  // Outcome of picking the next optional field.
  typedef struct packed {
    phase_t phase;
    logic   load_cnt;
  } opt_sel_t;

  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam logic [7:0]  SHORT_FIELD_LEN = 8'd2;
  localparam logic [7:0]  DC_FIXED_BYTES  = 8'd13;

endpackage

/* rtl/esdpe_front.sv */
// ----------------------------------------------------------------------------
// esdpe_front
// Byte parser: walks the descriptor fields and pushes payload words into
// the queue.
// ----------------------------------------------------------------------------
module esdpe_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_start_req,
  input  logic                    q_full,
  output logic                    push_valid,
  output esdpe_pkg::payload_word_t push_word
);

  esdpe_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]        flags_r, flags_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [31:0]       rem_r, rem_nxt;

  logic              accept;
  logic [7:0]        cnt_dec;
  logic [31:0]       size_shift;
  logic              size_end;
  esdpe_pkg::opt_sel_t opt;

  // Pick the first optional field at or after the given stage whose flag is set.
  function automatic esdpe_pkg::opt_sel_t enter_optional(
    input esdpe_pkg::opt_stage_t stage,
    input logic [2:0]            flags
  );
    esdpe_pkg::opt_sel_t sel;
    sel.load_cnt = 1'b0;
    if (stage == esdpe_pkg::OPT_DEP && flags[2]) begin
      sel.phase    = esdpe_pkg::PH_DEP;
      sel.load_cnt = 1'b1;
    end else if ((stage == esdpe_pkg::OPT_DEP || stage == esdpe_pkg::OPT_URL) &&
                 flags[1]) begin
      sel.phase = esdpe_pkg::PH_URLLEN;
    end else if (stage != esdpe_pkg::OPT_NONE && flags[0]) begin
      sel.phase    = esdpe_pkg::PH_OCR;
      sel.load_cnt = 1'b1;
    end else begin
      sel.phase = esdpe_pkg::PH_DCTAG;
    end
    return sel;
  endfunction

  // The queue is the only thing that holds the input back.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign cnt_dec    = cnt_r - 8'd1;
  assign size_shift = {size_r[24:0], in_data_byte[6:0]};
  assign size_end   = !in_data_byte[7];

  // Next phase and field bookkeeping for each accepted word.
  always_comb begin
    phase_nxt  = phase_r;
    flags_nxt  = flags_r;
    cnt_nxt    = cnt_r;
    size_nxt   = size_r;
    rem_nxt    = rem_r;
    push_valid = 1'b0;
    opt        = enter_optional(esdpe_pkg::OPT_NONE, 3'd0);
    push_word.data = in_data_byte;
    push_word.last = (rem_r == 32'd1);
    if (accept) begin
      if (in_start_req) begin
        phase_nxt = esdpe_pkg::PH_LEN;
        flags_nxt = 3'd0;
        cnt_nxt   = 8'd0;
        size_nxt  = 32'd0;
        rem_nxt   = 32'd0;
      end else begin
        case (phase_r)
          esdpe_pkg::PH_LEN: begin
            size_nxt = size_shift;
            if (size_end) begin
              size_nxt  = 32'd0;
              phase_nxt = esdpe_pkg::PH_ESID;
              cnt_nxt   = esdpe_pkg::SHORT_FIELD_LEN;
            end
          end
          esdpe_pkg::PH_ESID: begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == 8'd0) phase_nxt = esdpe_pkg::PH_FLAGS;
          end
          esdpe_pkg::PH_FLAGS: begin
            flags_nxt = in_data_byte[7:5];
            opt       = enter_optional(esdpe_pkg::OPT_DEP, in_data_byte[7:5]);
            phase_nxt = opt.phase;
            if (opt.load_cnt) cnt_nxt = esdpe_pkg::SHORT_FIELD_LEN;
          end
          esdpe_pkg::PH_DEP: begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == 8'd0) begin
              opt       = enter_optional(esdpe_pkg::OPT_URL, flags_r);
              phase_nxt = opt.phase;
              if (opt.load_cnt) cnt_nxt = esdpe_pkg::SHORT_FIELD_LEN;
            end
          end
          esdpe_pkg::PH_URLLEN: begin
            if (in_data_byte == 8'd0) begin
              opt       = enter_optional(esdpe_pkg::OPT_OCR, flags_r);
              phase_nxt = opt.phase;
              if (opt.load_cnt) cnt_nxt = esdpe_pkg::SHORT_FIELD_LEN;
            end else begin
              cnt_nxt   = in_data_byte;
              phase_nxt = esdpe_pkg::PH_URL;
            end
          end
          esdpe_pkg::PH_URL: begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == 8'd0) begin
              opt       = enter_optional(esdpe_pkg::OPT_OCR, flags_r);
              phase_nxt = opt.phase;
              if (opt.load_cnt) cnt_nxt = esdpe_pkg::SHORT_FIELD_LEN;
            end
          end
          esdpe_pkg::PH_OCR: begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == 8'd0) phase_nxt = esdpe_pkg::PH_DCTAG;
          end
          esdpe_pkg::PH_DCTAG: begin
            size_nxt  = 32'd0;
            phase_nxt = esdpe_pkg::PH_DCLEN;
          end
          esdpe_pkg::PH_DCLEN: begin
            size_nxt = size_shift;
            if (size_end) begin
              size_nxt  = 32'd0;
              phase_nxt = esdpe_pkg::PH_DCFIX;
              cnt_nxt   = esdpe_pkg::DC_FIXED_BYTES;
            end
          end
          esdpe_pkg::PH_DCFIX: begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == 8'd0) phase_nxt = esdpe_pkg::PH_INTAG;
          end
          esdpe_pkg::PH_INTAG: begin
            size_nxt  = 32'd0;
            phase_nxt = esdpe_pkg::PH_INLEN;
          end
          esdpe_pkg::PH_INLEN: begin
            size_nxt = size_shift;
            if (size_end) begin
              rem_nxt   = size_shift;
              phase_nxt = (size_shift != 32'd0) ? esdpe_pkg::PH_PAYLOAD
                                                : esdpe_pkg::PH_DONE;
            end
          end
          esdpe_pkg::PH_PAYLOAD: begin
            push_valid = 1'b1;
            rem_nxt    = rem_r - 32'd1;
            if (rem_r == 32'd1) phase_nxt = esdpe_pkg::PH_DONE;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= esdpe_pkg::PH_IDLE;
      flags_r <= 3'd0;
      cnt_r   <= 8'd0;
      size_r  <= 32'd0;
      rem_r   <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      cnt_r   <= cnt_nxt;
      size_r  <= size_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // The payload phase always has at least one word left to send.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == esdpe_pkg::PH_PAYLOAD |-> rem_r != 32'd0)
    else $error("payload phase with nothing remaining");

  // A start word restarts parsing with cleared counters.
  a_start_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_start_req |=> phase_r == esdpe_pkg::PH_LEN && rem_r == 32'd0)
    else $error("start word did not restart the parser");

  // Only payload-phase words reach the queue.
  a_push_phase: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> phase_r == esdpe_pkg::PH_PAYLOAD && !in_start_req)
    else $error("push outside the payload phase");

endmodule

/* rtl/esdpe_queue.sv */
// ----------------------------------------------------------------------------
// esdpe_queue
// Short register queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module esdpe_queue #(
  parameter int unsigned Depth = esdpe_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  input  esdpe_pkg::payload_word_t push_word,
  output logic                    q_full,
  input  logic                    pop,
  output logic                    q_valid,
  output esdpe_pkg::payload_word_t q_word
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  esdpe_pkg::payload_word_t entries_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign q_full  = (count_r == CntW'(Depth));
  assign q_valid = (count_r != '0);
  assign q_word  = entries_r[rd_ptr_r];
  assign do_push = push_valid && !q_full;
  assign do_pop  = pop && q_valid;

  // Pointer and fill count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_word;
    end
  end

  // The fill count never passes the depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("queue count exceeds depth");

  // The parser never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !q_full)
    else $error("push into full queue");

  // The output stage never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

/* rtl/esdpe_back.sv */
// ----------------------------------------------------------------------------
// esdpe_back
// Output register stage: takes words from the queue and holds them while
// the receiver stalls.
// ----------------------------------------------------------------------------
module esdpe_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  esdpe_pkg::payload_word_t q_word,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_payload_byte,
  output logic                    out_payload_last
);

  logic                     out_valid_r, out_valid_nxt;
  esdpe_pkg::payload_word_t word_r;
  logic                     load;

  // The register takes a new word when empty or when its word leaves.
  assign load = !out_valid_r || !out_stall;
  assign pop  = load && q_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = q_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (pop) word_r <= q_word;
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = word_r.data;
  assign out_payload_last = word_r.last;

  // A word waiting in the queue fills an empty output register.
  a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && q_valid |-> pop)
    else $error("output register left empty with queued word");

endmodule

/* rtl/es_descriptor_payload_extract.sv */
// ----------------------------------------------------------------------------
// es_descriptor_payload_extract
// Extracts the decoder-specific payload from an ES descriptor byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data_byte, in_start_req) takes
//   one descriptor byte per word; in_start_req marks the tag byte of a new
//   descriptor and restarts the parser. The output channel (out_valid,
//   out_stall, out_payload_byte, out_payload_last) returns one word per
//   payload byte, with out_payload_last on the final one.
//   Throughput is one input word per cycle while in_stall is low. A payload
//   byte accepted by the parser is written into the queue at the same edge
//   and moves from the queue into the output register when that can load.
//   When the receiver stalls, the output register holds its word and the
//   queue (QueueDepth entries) fills; in_stall rises only when the queue is
//   full, so up to QueueDepth + 1 payload words are held before input stops.
//   Non-payload bytes never produce output and are taken even while the
//   output is stalled, as long as the queue has room.
//   Reset (rst_n low, synchronous) empties the queue and output register and
//   puts the parser in its wait-for-start phase; bytes before the first
//   start word are dropped.
// ----------------------------------------------------------------------------
module es_descriptor_payload_extract #(
  parameter int unsigned QueueDepth = esdpe_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_req,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_payload_last
);

  logic                     q_full;
  logic                     push_valid;
  esdpe_pkg::payload_word_t push_word;
  logic                     pop;
  logic                     q_valid;
  esdpe_pkg::payload_word_t q_word;

  // Parser front end.
  esdpe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_start_req (in_start_req),
    .q_full       (q_full),
    .push_valid   (push_valid),
    .push_word    (push_word)
  );

  // Decoupling queue.
  esdpe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_word  (push_word),
    .q_full     (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_word     (q_word)
  );

  // Output stage.
  esdpe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_word           (q_word),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_payload_last (out_payload_last)
  );

endmodule
